[rtl/core/sp_pkg.sv]
`default_nettype none
package sp_pkg;

  localparam int IN_W     = 24;          // Q8.16 input coordinates
  localparam int OUT_W    = 32;          // Q16.16 results
  localparam int SUM_W    = 48;          // x*x + y*y + z*z, Q16.32
  localparam int LEN_W    = 24;          // floor square root, Q8.16
  localparam int DIVR_W   = 25;          // d = len + z, Q9.16
  localparam int LD_W     = LEN_W + DIVR_W;  // len * d
  localparam int NUM_W    = 56;          // widest rounded numerator
  localparam int QUO_W    = 32;          // quotient bits kept below the overflow flag
  localparam int SQRT_LAT = LEN_W;       // one root bit per stage
  localparam int DIV_LAT  = QUO_W + 1;   // overflow check plus one quotient bit per stage

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [0:0] REG_MIN_DIVISOR = 1'b0;
  localparam logic [IN_W-1:0] MIN_DIV_RST = IN_W'(1);

  typedef struct packed {
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_res_t;

endpackage
`default_nettype wire

[rtl/core/sp_if.sv]
`default_nettype none
interface sp_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [sp_pkg::IN_W-1:0] point_x;
  logic signed [sp_pkg::IN_W-1:0] point_y;
  logic signed [sp_pkg::IN_W-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface sp_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [sp_pkg::OUT_W-1:0] image_x;
  logic signed [sp_pkg::OUT_W-1:0] image_y;
  logic signed [sp_pkg::OUT_W-1:0] inv_divisor;
  logic signed [sp_pkg::OUT_W-1:0] jac_x_by_z;
  logic signed [sp_pkg::OUT_W-1:0] jac_y_by_z;
  logic                            valid_res;

  modport source (output valid, image_x, image_y, inv_divisor, jac_x_by_z, jac_y_by_z,
                  valid_res, input ready);
  modport sink   (input valid, image_x, image_y, inv_divisor, jac_x_by_z, jac_y_by_z,
                  valid_res, output ready);
endinterface
`default_nettype wire

[rtl/core/sp_sqrt.sv]
`default_nettype none
module sp_sqrt (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [sp_pkg::SUM_W-1:0] radicand,
  output logic      [sp_pkg::LEN_W-1:0] root
);
  import sp_pkg::*;

  logic [SUM_W-1:0] rem_r  [SQRT_LAT];
  logic [LEN_W-1:0] root_r [SQRT_LAT];

  // Restoring square root on the remainder S - root^2, one root bit per stage.
  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
    localparam int B = LEN_W - 1 - k;
    logic [SUM_W-1:0] rem_in;
    logic [SUM_W-1:0] trial;
    logic [LEN_W-1:0] root_in;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in  = radicand;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign trial = (SUM_W'(root_in) << (B + 1)) | (SUM_W'(1) << (2 * B));
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (rem_in - trial) : rem_in;
        root_r[k] <= ge ? (root_in | (LEN_W'(1) << B)) : root_in;
      end
    end
  end

  assign root = root_r[SQRT_LAT-1];

endmodule
`default_nettype wire

[rtl/core/sp_div.sv]
`default_nettype none
module sp_div (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [sp_pkg::NUM_W-1:0] num,
  input  wire logic [sp_pkg::LD_W-1:0]  den,
  output sp_pkg::div_res_t              res
);
  import sp_pkg::*;

  logic [NUM_W-1:0] rem_r [DIV_LAT];
  logic [LD_W-1:0]  den_r [DIV_LAT];
  logic [QUO_W-1:0] quo_r [DIV_LAT];
  logic             ovf_r [DIV_LAT];

  // Flag quotients of 2^QUO_W or more up front; the bit stages then never overflow.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      quo_r[0] <= '0;
      ovf_r[0] <= LD_W'(num[NUM_W-1:QUO_W]) >= den;
    end
  end

  for (genvar k = 1; k < DIV_LAT; k++) begin : g_stage
    localparam int B = QUO_W - k;
    logic [NUM_W-1:0] shifted;
    logic [NUM_W-1:0] sub;
    logic             ge;

    assign shifted = rem_r[k-1] >> B;
    assign ge      = shifted >= NUM_W'(den_r[k-1]);
    assign sub     = NUM_W'(den_r[k-1]) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? (rem_r[k-1] - sub) : rem_r[k-1];
        den_r[k] <= den_r[k-1];
        quo_r[k] <= ge ? (quo_r[k-1] | (QUO_W'(1) << B)) : quo_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign res.ovf = ovf_r[DIV_LAT-1];
  assign res.quo = quo_r[DIV_LAT-1];

endmodule
`default_nettype wire

[rtl/core/stereographic_projection_jacobian.sv]
// Throughput: one point per cycle while the output is not stalled; the pipeline includes 24
// square-root stages (one root bit each) and 33 divider stages (an overflow check, then one
// quotient bit each), all advancing on one shared enable.
// A stalled output freezes every stage, and the input stalls with it.
// Reset (rst_n low, synchronous) clears all valid bits and sets min_divisor to 1.
`default_nettype none
module stereographic_projection_jacobian (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  sp_in_if.sink                          in_chan,
  sp_out_if.source                       out_chan,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [sp_pkg::CFG_AW-1:0] paddr,
  input  wire logic [sp_pkg::CFG_DW-1:0] pwdata,
  output logic      [sp_pkg::CFG_DW-1:0] prdata,
  output logic                           pready
);
  import sp_pkg::*;

  // Per-point side data carried alongside the square root.
  typedef struct packed {
    logic [IN_W-1:0] ax;
    logic [IN_W-1:0] ay;
    logic [IN_W-1:0] az;
    logic            xneg;
    logic            xpos;
    logic            yneg;
    logic            ypos;
    logic            zneg;
  } meta_a_t;

  // Signs and failure flag carried alongside the dividers.
  typedef struct packed {
    logic xneg;
    logic xpos;
    logic yneg;
    logic ypos;
    logic fail;
  } meta_b_t;

  function automatic logic [OUT_W-1:0] sat32(input logic neg, input div_res_t q);
    logic [OUT_W-1:0] r;
    if (q.ovf) begin
      r = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else if (neg) begin
      r = q.quo[QUO_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(~q.quo + QUO_W'(1));
    end else begin
      r = q.quo[QUO_W-1] ? {1'b0, {(OUT_W-1){1'b1}}} : OUT_W'(q.quo);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration: one register, written in the APB access phase.
  // ---------------------------------------------------------------------------
  logic [IN_W-1:0] min_div_r;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MIN_DIVISOR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_div_r <= MIN_DIV_RST;
    end else if (cfg_wr) begin
      min_div_r <= pwdata[IN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MIN_DIVISOR) ? CFG_DW'(min_div_r) : '0;

  // ---------------------------------------------------------------------------
  // Global advance: move every stage when the output register is free or taken.
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_valid_r;

  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  // Stage 1: magnitudes, signs and squares.
  logic [IN_W-1:0]  ax, ay, az;
  logic             v1_r;
  logic [SUM_W-1:0] sqx_r, sqy_r, sqz_r;
  meta_a_t          m1_r;

  assign ax = in_chan.point_x[IN_W-1] ? (~in_chan.point_x + IN_W'(1)) : in_chan.point_x;
  assign ay = in_chan.point_y[IN_W-1] ? (~in_chan.point_y + IN_W'(1)) : in_chan.point_y;
  assign az = in_chan.point_z[IN_W-1] ? (~in_chan.point_z + IN_W'(1)) : in_chan.point_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r   <= SUM_W'(ax) * SUM_W'(ax);
      sqy_r   <= SUM_W'(ay) * SUM_W'(ay);
      sqz_r   <= SUM_W'(az) * SUM_W'(az);
      m1_r.ax <= ax;
      m1_r.ay <= ay;
      m1_r.az <= az;
      m1_r.xneg <= in_chan.point_x[IN_W-1];
      m1_r.xpos <= !in_chan.point_x[IN_W-1] && (|in_chan.point_x);
      m1_r.yneg <= in_chan.point_y[IN_W-1];
      m1_r.ypos <= !in_chan.point_y[IN_W-1] && (|in_chan.point_y);
      m1_r.zneg <= in_chan.point_z[IN_W-1];
    end
  end

  // Stage 2: sum of squares.
  logic             v2_r;
  logic [SUM_W-1:0] sum_r;
  meta_a_t          m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= sqx_r + sqy_r + sqz_r;
      m2_r  <= m1_r;
    end
  end

  // Square root: side data and valid bits ride a matching delay line.
  logic [LEN_W-1:0] len;
  logic             sv_r [SQRT_LAT];
  meta_a_t          sm_r [SQRT_LAT];

  sp_sqrt u_sqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (sum_r),
    .root     (len)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_LAT; k++) sv_r[k] <= 1'b0;
    end else if (adv) begin
      sv_r[0] <= v2_r;
      for (int k = 1; k < SQRT_LAT; k++) sv_r[k] <= sv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm_r[0] <= m2_r;
      for (int k = 1; k < SQRT_LAT; k++) sm_r[k] <= sm_r[k-1];
    end
  end

  // Stage 3: divisor d = len + z; floor root keeps len >= |z|.
  logic              v3_r;
  logic [DIVR_W-1:0] d3_r;
  logic [LEN_W-1:0]  len3_r;
  meta_a_t           m3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= sv_r[SQRT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d3_r   <= sm_r[SQRT_LAT-1].zneg ? (DIVR_W'(len) - DIVR_W'(sm_r[SQRT_LAT-1].az))
                                      : (DIVR_W'(len) + DIVR_W'(sm_r[SQRT_LAT-1].az));
      len3_r <= len;
      m3_r   <= sm_r[SQRT_LAT-1];
    end
  end

  // Stage 4: len * d and the failure test against the minimum divisor.
  logic              v4_r;
  logic [DIVR_W-1:0] d4_r;
  logic [LD_W-1:0]   ld4_r;
  logic              fail4_r;
  meta_a_t           m4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d4_r    <= d3_r;
      ld4_r   <= LD_W'(len3_r) * LD_W'(d3_r);
      fail4_r <= (d3_r == '0) || (d3_r < DIVR_W'(min_div_r));
      m4_r    <= m3_r;
    end
  end

  // Stage 5: rounded numerators (add half the divisor), divisors.
  logic             v5_r;
  logic [NUM_W-1:0] n_r [5];
  logic [LD_W-1:0]  dd_r;
  logic [LD_W-1:0]  dl_r;
  meta_b_t          m5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r[0]    <= (NUM_W'(m4_r.ax) << 16) + NUM_W'(d4_r >> 1);
      n_r[1]    <= (NUM_W'(m4_r.ay) << 16) + NUM_W'(d4_r >> 1);
      n_r[2]    <= (NUM_W'(1) << 32) + NUM_W'(d4_r >> 1);
      n_r[3]    <= (NUM_W'(m4_r.ax) << 32) + NUM_W'(ld4_r >> 1);
      n_r[4]    <= (NUM_W'(m4_r.ay) << 32) + NUM_W'(ld4_r >> 1);
      dd_r      <= LD_W'(d4_r);
      dl_r      <= ld4_r;
      m5_r.xneg <= m4_r.xneg;
      m5_r.xpos <= m4_r.xpos;
      m5_r.yneg <= m4_r.yneg;
      m5_r.ypos <= m4_r.ypos;
      m5_r.fail <= fail4_r;
    end
  end

  // Five dividers in lockstep; side data rides a matching delay line.
  div_res_t q [5];
  logic     dv_r [DIV_LAT];
  meta_b_t  dm_r [DIV_LAT];

  for (genvar j = 0; j < 5; j++) begin : g_div
    sp_div u_div (
      .clk (clk),
      .en  (adv),
      .num (n_r[j]),
      .den ((j < 3) ? dd_r : dl_r),
      .res (q[j])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) dv_r[k] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= v5_r;
      for (int k = 1; k < DIV_LAT; k++) dv_r[k] <= dv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dm_r[0] <= m5_r;
      for (int k = 1; k < DIV_LAT; k++) dm_r[k] <= dm_r[k-1];
    end
  end

  // Output register: apply signs, saturate, zero everything on failure.
  meta_b_t          mo;
  logic [OUT_W-1:0] ix_r, iy_r, inv_r, jx_r, jy_r;
  logic             ok_r;

  assign mo = dm_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ix_r  <= mo.fail ? '0 : sat32(mo.xneg, q[0]);
      iy_r  <= mo.fail ? '0 : sat32(mo.yneg, q[1]);
      inv_r <= mo.fail ? '0 : sat32(1'b0, q[2]);
      jx_r  <= mo.fail ? '0 : sat32(mo.xpos, q[3]);
      jy_r  <= mo.fail ? '0 : sat32(mo.ypos, q[4]);
      ok_r  <= !mo.fail;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.image_x     = ix_r;
  assign out_chan.image_y     = iy_r;
  assign out_chan.inv_divisor = inv_r;
  assign out_chan.jac_x_by_z  = jx_r;
  assign out_chan.jac_y_by_z  = jy_r;
  assign out_chan.valid_res   = ok_r;

`ifndef NO_ASSERTIONS
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !ok_r |-> (ix_r == '0) && (iy_r == '0) && (inv_r == '0) &&
                             (jx_r == '0) && (jy_r == '0))
    else $error("failed projection carries nonzero fields");

  a_inv_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ok_r |-> !inv_r[OUT_W-1])
    else $error("1/d came out negative");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> v1_r)
    else $error("transfer did not enter the pipeline");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(dv_r[DIV_LAT-1]) && $stable(sv_r[SQRT_LAT-1]))
    else $error("stage moved during a stall");
`endif

endmodule
`default_nettype wire

[bench/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sp_pkg::*;

  localparam int LATENCY  = 63;
  localparam int WD_LIMIT = 4000;

  typedef struct packed {
    logic [OUT_W-1:0] image_x;
    logic [OUT_W-1:0] image_y;
    logic [OUT_W-1:0] inv_divisor;
    logic [OUT_W-1:0] jac_x_by_z;
    logic [OUT_W-1:0] jac_y_by_z;
    logic             valid_res;
  } projection_t;

  // One row of the directed table; has_fixed marks rows with a hand-typed result
  typedef struct {
    logic [IN_W-1:0] px;
    logic [IN_W-1:0] py;
    logic [IN_W-1:0] pz;
    bit              has_fixed;
    projection_t     fixed;
  } point_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  sp_in_if  in_chan ();
  sp_out_if out_chan ();

  stereographic_projection_jacobian i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model-side copy of the register and the queue of pending projections
  logic [IN_W-1:0] min_div_model;
  projection_t     pending_proj[$];
  int              fail_count = 0;
  int              idle_cycles = 0;
  bit              stall_enable = 1'b1;

  // Round-to-nearest quotient, then sign and saturate to 32 bits
  function automatic logic [OUT_W-1:0] signed_quotient(bit neg, logic [63:0] num,
                                                       logic [63:0] den);
    logic [63:0] mag;
    mag = (num + (den >> 1)) / den;
    if (neg) begin
      if (mag >= 64'h8000_0000) return 32'h8000_0000;
      return 32'(64'd0 - mag);
    end
    if (mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[OUT_W-1:0];
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic projection_t project_point(logic [IN_W-1:0] px, logic [IN_W-1:0] py,
                                                logic [IN_W-1:0] pz);
    projection_t res;
    logic signed [IN_W-1:0] sx, sy, sz;
    logic [63:0] ax, ay, az, len, d, ld;
    sx = px; sy = py; sz = pz;
    ax = sx < 0 ? 64'(-64'(sx)) : 64'(sx);
    ay = sy < 0 ? 64'(-64'(sy)) : 64'(sy);
    az = sz < 0 ? 64'(-64'(sz)) : 64'(sz);
    len = floor_root(ax * ax + ay * ay + az * az);
    d = sz < 0 ? len - az : len + az;
    res = '0;
    // Zero divisor fails even with the minimum at zero
    if (d == 0 || d < 64'(min_div_model)) return res;
    ld = len * d;
    res.image_x     = signed_quotient(sx < 0, ax << 16, d);
    res.image_y     = signed_quotient(sy < 0, ay << 16, d);
    res.inv_divisor = signed_quotient(1'b0, 64'd1 << 32, d);
    res.jac_x_by_z  = signed_quotient(sx > 0, ax << 32, ld);
    res.jac_y_by_z  = signed_quotient(sy > 0, ay << 32, ld);
    res.valid_res   = 1'b1;
    return res;
  endfunction

  // Setup then access phase; the register takes the value on the access edge
  task automatic write_min_divisor(logic [IN_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(REG_MIN_DIVISOR) << 2;
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    min_div_model = value;
  endtask

  // Hold the last point valid until it transfers; scoreboard on acceptance
  task automatic send_point(logic [IN_W-1:0] px, logic [IN_W-1:0] py, logic [IN_W-1:0] pz);
    in_chan.valid   <= 1'b1;
    in_chan.point_x <= px;
    in_chan.point_y <= py;
    in_chan.point_z <= pz;
    do @(posedge clk); while (!in_chan.ready);
    pending_proj.push_back(project_point(px, py, pz));
  endtask

  task automatic idle_sender(int cycles);
    in_chan.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (pending_proj.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // Random coordinate biased toward extremes and small values
  function automatic logic [IN_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return IN_W'($urandom_range(0, 512)) ^ ($urandom_range(0, 1) ? 24'hFFFFFF : 24'h0);
      default: return IN_W'($urandom);
    endcase
  endfunction

  // Compare the transfer against the oldest projection
  always @(posedge clk) begin
    projection_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_proj.size() == 0) begin
        $error("unexpected result transfer");
        fail_count++;
      end else begin
        want = pending_proj.pop_front();
        if (out_chan.image_x !== want.image_x) begin
          $error("image_x expected %h got %h", want.image_x, out_chan.image_x);
          fail_count++;
        end
        if (out_chan.image_y !== want.image_y) begin
          $error("image_y expected %h got %h", want.image_y, out_chan.image_y);
          fail_count++;
        end
        if (out_chan.inv_divisor !== want.inv_divisor) begin
          $error("inv_divisor expected %h got %h", want.inv_divisor, out_chan.inv_divisor);
          fail_count++;
        end
        if (out_chan.jac_x_by_z !== want.jac_x_by_z) begin
          $error("jac_x_by_z expected %h got %h", want.jac_x_by_z, out_chan.jac_x_by_z);
          fail_count++;
        end
        if (out_chan.jac_y_by_z !== want.jac_y_by_z) begin
          $error("jac_y_by_z expected %h got %h", want.jac_y_by_z, out_chan.jac_y_by_z);
          fail_count++;
        end
        if (out_chan.valid_res !== want.valid_res) begin
          $error("valid_res expected %b got %b", want.valid_res, out_chan.valid_res);
          fail_count++;
        end
      end
    end
  end

  // Receiver stall pattern: long ready runs, occasional stall bursts
  always @(posedge clk) begin
    if (!stall_enable) begin
      out_chan.ready <= 1'b1;
    end else if ($urandom_range(0, 15) == 0) begin
      out_chan.ready <= 1'b0;
    end else if (!out_chan.ready) begin
      out_chan.ready <= ($urandom_range(0, 3) == 0);
    end else begin
      out_chan.ready <= ($urandom_range(0, 5) != 0);
    end
  end

  // Watchdog: count cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WD_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    point_row_t rows[$];
    point_row_t row;
    logic [IN_W-1:0] div_settings[4];
    int burst;

    in_chan.valid   = 1'b0;
    in_chan.point_x = '0;
    in_chan.point_y = '0;
    in_chan.point_z = '0;
    min_div_model   = MIN_DIV_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: origin and negative z axis give a zero divisor
    rows.push_back('{24'h0, 24'h0, 24'h0, 1'b1, '0});
    rows.push_back('{24'h0, 24'h0, 24'hFF0000, 1'b1, '0});
    rows.push_back('{24'h0, 24'h0, 24'h800000, 1'b1, '0});
    // Unit z: d = 2.0, 1/d = 0.5
    rows.push_back('{24'h0, 24'h0, 24'h010000, 1'b1,
                    '{32'h0, 32'h0, 32'h8000, 32'h0, 32'h0, 1'b1}});
    // Tiny divisor (d = 2 LSB): 1/d saturates
    rows.push_back('{24'h0, 24'h0, 24'h000001, 1'b1,
                    '{32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1}});
    rows.push_back('{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0, '0});
    rows.push_back('{24'h800000, 24'h800000, 24'h800000, 1'b0, '0});
    rows.push_back('{24'h800000, 24'h7FFFFF, 24'h0, 1'b0, '0});
    rows.push_back('{24'h7FFFFF, 24'h800000, 24'h000001, 1'b0, '0});
    rows.push_back('{24'h000001, 24'hFFFFFF, 24'h800000, 1'b0, '0});
    rows.push_back('{24'h7FFFFF, 24'h0, 24'h800001, 1'b0, '0});
    rows.push_back('{24'h000001, 24'h000001, 24'hFFFFFF, 1'b0, '0});
    rows.push_back('{24'h123456, 24'hABCDEF, 24'h555555, 1'b0, '0});
    rows.push_back('{24'hFFFFFF, 24'h000000, 24'h000000, 1'b0, '0});

    @(posedge clk);
    foreach (rows[i]) begin
      row = rows[i];
      send_point(row.px, row.py, row.pz);
      // Check the prediction against the typed result where one is given, then replace it
      if (row.has_fixed) begin
        if (pending_proj[$] !== row.fixed) begin
          $error("directed row %0d: predictor disagrees with table", i);
          fail_count++;
        end
        pending_proj[$] = row.fixed;
      end
    end
    drain_results();

    // Walk several minimum-divisor settings, extremes included
    div_settings = '{24'h000000, 24'hFFFFFF, 24'h010000, 24'h800000};
    foreach (div_settings[s]) begin
      write_min_divisor(div_settings[s]);
      stall_enable = (s != 2);
      for (int n = 0; n < 110; ) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && n < 110; b++, n++) begin
          send_point(rand_coord(), rand_coord(), rand_coord());
        end
        if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
        // Pause until the pipeline is empty when a burst ends with n in 51..59
        if (n > 50 && n < 60) begin
          in_chan.valid <= 1'b0;
          while (pending_proj.size() != 0) @(posedge clk);
        end
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/sp_pkg.sv
rtl/core/sp_if.sv
rtl/core/sp_sqrt.sv
rtl/core/sp_div.sv
rtl/core/stereographic_projection_jacobian.sv
bench/testbench.sv
